### rtl/tfcm_pkg.sv
// ============================================================================
// tfcm_pkg
// Shared types and constants of the thermal false-color mapper.
// ============================================================================
package tfcm_pkg;

   // Item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LOW_LEVEL  = 2'd0,
      CSR_HIGH_LEVEL = 2'd1,
      CSR_ENTRIES    = 2'd2
   } csr_index_type;

   localparam int LEVEL_W = 16;
   localparam int COUNT_W = 11;
   localparam int QUO_W   = COUNT_W;            // quotient stays below 2**COUNT_W
   localparam int REM_W   = LEVEL_W + COUNT_W;  // offset times (entries - 1)
   localparam int HALF_W  = COUNT_W - 1;
   localparam int IDX_W   = 10;
   localparam int RGB_W   = 24;

   // One beat as it moves through the divider stages
   typedef struct packed {
      logic               op;
      logic               zero_span;
      logic [QUO_W-1:0]   quo;
      logic [REM_W-1:0]   rem;
      logic [LEVEL_W-1:0] span;
      logic [HALF_W-1:0]  half;
      logic [IDX_W-1:0]   idx;
      logic [RGB_W-1:0]   rgb;
   } item_type;

endpackage

### rtl/tfcm_div_stage.sv
// ============================================================================
// tfcm_div_stage
// One restoring-division step: resolves quotient bit STEP and registers it.
// ============================================================================
module tfcm_div_stage import tfcm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);

   logic             valid_ff;
   item_type         item_ff;
   item_type         item_in;
   logic [REM_W-1:0] shifted;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = REM_W'(in_item.span) << STEP;
      item_in = in_item;
      if (in_item.rem >= shifted) begin
         item_in.rem       = in_item.rem - shifted;
         item_in.quo[STEP] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/thermal_false_color_mapper.sv
// ============================================================================
// thermal_false_color_mapper
// Maps 16-bit thermal samples to RGB through a writable palette.
// ============================================================================
// Usage:
//   req_* carries one item per beat. op OP_WRITE stores entry_red/green/blue
//   at entry_index and yields no response; op OP_MAP clamps pixel_value to
//   [low_level, high_level], scales it to an entry index and returns that
//   entry's color on rsp_*. Palette writes and lookups keep stream order.
//   csr_* writes low_level, high_level and entries_in_use; write them only
//   while no beat is in flight. csr_ready is always high.
// Pipeline and throughput:
//   A beat passes 14 register stages: one clamp stage (loaded at the
//   accepting edge), one multiply stage, 11 restoring-division stages (one
//   quotient bit each) and the palette read stage. One beat per cycle
//   enters and leaves when rsp_ready stays high.
// Reset:
//   Empties the pipeline and restores the level and entry registers. The
//   palette is not cleared; read only entries written before.
// Stall:
//   When rsp_ready is low the held response stays, and stages fill up
//   behind it; req_ready drops only when every stage is occupied.
// ============================================================================
module thermal_false_color_mapper import tfcm_pkg::*; #(
   parameter int PALETTE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [LEVEL_W-1:0] req_pixel_value,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [7:0]         req_entry_red,
   input  logic [7:0]         req_entry_green,
   input  logic [7:0]         req_entry_blue,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [LEVEL_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);
   // Largest usable entry count: the palette size or the register's range
   localparam int N_MAX  = (PALETTE_DEPTH < (2 ** COUNT_W - 1)) ?
                           PALETTE_DEPTH : (2 ** COUNT_W - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [LEVEL_W-1:0] low_ff;
   logic [LEVEL_W-1:0] high_ff;
   logic [COUNT_W-1:0] entries_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= '0;
         high_ff    <= '1;
         entries_ff <= COUNT_W'(1024);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_LEVEL:  low_ff     <= csr_data;
            CSR_HIGH_LEVEL: high_ff    <= csr_data;
            CSR_ENTRIES:    entries_ff <= csr_data[COUNT_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: clamp the sample, form offset, span and entry count
   // ---------------------------------------------------------------------
   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic               s1_zero_ff;
   logic [LEVEL_W-1:0] s1_off_ff;
   logic [LEVEL_W-1:0] s1_span_ff;
   logic [COUNT_W-1:0] s1_nm1_ff;
   logic [HALF_W-1:0]  s1_half_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [RGB_W-1:0]   s1_rgb_ff;

   logic               s1_zero_in;
   logic [LEVEL_W-1:0] s1_off_in;
   logic [LEVEL_W-1:0] s1_sample;
   logic [COUNT_W-1:0] s1_n;
   logic               s1_ready;

   always_comb begin
      // entry count limited to [2, N_MAX]
      if (entries_ff < COUNT_W'(2)) begin
         s1_n = COUNT_W'(2);
      end else if (32'(entries_ff) > N_MAX) begin
         s1_n = COUNT_W'(N_MAX);
      end else begin
         s1_n = entries_ff;
      end
      // inverted or equal levels collapse to the middle entry
      s1_zero_in = (high_ff <= low_ff);
      s1_sample  = req_pixel_value;
      if (s1_sample < low_ff) begin
         s1_sample = low_ff;
      end
      if (s1_sample > high_ff) begin
         s1_sample = high_ff;
      end
      s1_off_in = s1_sample - low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff   <= req_op;
         s1_zero_ff <= s1_zero_in;
         s1_off_ff  <= s1_off_in;
         s1_span_ff <= high_ff - low_ff;
         s1_nm1_ff  <= s1_n - COUNT_W'(1);
         s1_half_ff <= s1_n[COUNT_W-1:1];
         s1_idx_ff  <= req_entry_index;
         s1_rgb_ff  <= {req_entry_red, req_entry_green, req_entry_blue};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: dividend = offset * (entries - 1)
   // ---------------------------------------------------------------------
   logic     s2_valid_ff;
   item_type s2_item_ff;
   item_type s2_item_in;
   logic     s2_ready;

   logic     div_valid [QUO_W+1];
   item_type div_item  [QUO_W+1];
   logic     div_ready [QUO_W+1];

   assign s2_ready  = !s2_valid_ff || div_ready[0];
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      s2_item_in.op        = s1_op_ff;
      s2_item_in.zero_span = s1_zero_ff;
      s2_item_in.quo       = '0;
      s2_item_in.rem       = REM_W'(s1_off_ff) * REM_W'(s1_nm1_ff);
      s2_item_in.span      = s1_span_ff;
      s2_item_in.half      = s1_half_ff;
      s2_item_in.idx       = s1_idx_ff;
      s2_item_in.rgb       = s1_rgb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 3..13: restoring division, most significant quotient bit first
   // ---------------------------------------------------------------------
   assign div_valid[0] = s2_valid_ff;
   assign div_item[0]  = s2_item_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      tfcm_div_stage #(
         .STEP (QUO_W - 1 - k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_item   (div_item[k]),
         .in_ready  (div_ready[k]),
         .out_valid (div_valid[k+1]),
         .out_item  (div_item[k+1]),
         .out_ready (div_ready[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Stage 14: palette write or lookup; the read register is the output
   // ---------------------------------------------------------------------
   logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rsp_rgb_ff;
   logic             rsp_valid_ff;
   logic             mem_ready;
   logic             mem_take;
   logic [QUO_W-1:0] pos;
   logic [31:0]      rd_wide;
   logic [31:0]      wr_wide;
   logic             wr_en;
   logic             rd_en;
   item_type         last;

   assign last      = div_item[QUO_W];
   assign mem_ready = !rsp_valid_ff || rsp_ready;
   assign mem_take  = mem_ready && div_valid[QUO_W];
   assign div_ready[QUO_W] = mem_ready;

   always_comb begin
      pos = last.zero_span ? QUO_W'(last.half) : last.quo;
      rd_wide = 32'(pos);
      if (rd_wide >= PALETTE_DEPTH) begin
         rd_wide = 32'(PALETTE_DEPTH - 1);
      end
      wr_wide = 32'(last.idx);
      // drop writes beyond the palette
      wr_en = mem_take && (last.op == OP_WRITE) && (wr_wide < PALETTE_DEPTH);
      rd_en = mem_take && (last.op == OP_MAP);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[wr_wide[ADDR_W-1:0]] <= last.rgb;
      end
      if (rd_en) begin
         rsp_rgb_ff <= palette_mem[rd_wide[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mem_ready) begin
         rsp_valid_ff <= div_valid[QUO_W] && (last.op == OP_MAP);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_rgb_ff[23:16];
   assign rsp_out_green = rsp_rgb_ff[15:8];
   assign rsp_out_blue  = rsp_rgb_ff[7:0];

`ifndef NO_ASSERTIONS
   // A palette write leaves no response behind it
   assert property (@(posedge clock) disable iff (reset)
      (mem_take && last.op == OP_WRITE) |=> !rsp_valid)
      else $error("palette write produced a response");

   // Division finished: remainder must be below the span
   assert property (@(posedge clock) disable iff (reset)
      (div_valid[QUO_W] && last.op == OP_MAP && !last.zero_span)
      |-> (last.rem < REM_W'(last.span)))
      else $error("divider remainder not reduced below span");

   // A new response only comes from a map beat leaving the divider
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(div_valid[QUO_W] && last.op == OP_MAP))
      else $error("response appeared without a map beat");

   // Backpressure reaches the request side only when stages 1 and 2 are occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff))
      else $error("request stalled with free pipeline stages");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: thermal false-color mapper testbench
// Streams palette writes and pixel lookups through the mapper under random
// idling on both channels. A built-in predictor of the level clamp, index
// scaling and palette keeps the expected colors. Every response is checked
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import tfcm_pkg::*;

   localparam int          DEPTH      = 1024;
   localparam int          IDLE_LIMIT = 4000;  // cycles without any beat before giving up
   localparam int          LONG_HOLD  = 400;   // receiver hold-off that backs up the pipeline
   localparam int          DRAIN_WAIT = 24;    // covers palette writes still in the pipeline
   localparam logic [1:0]  CSR_SPARE  = 2'd3;  // unmapped register index, writes are dropped

   typedef struct {
      logic        op;
      logic [15:0] pixel;
      logic [9:0]  idx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } pixel_beat_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // DUT ports; every input starts at a known value
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_op          = OP_WRITE;
   logic [15:0] req_pixel_value = '0;
   logic [9:0]  req_entry_index = '0;
   logic [7:0]  req_entry_red   = '0;
   logic [7:0]  req_entry_green = '0;
   logic [7:0]  req_entry_blue  = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index       = CSR_LOW_LEVEL;
   logic [15:0] csr_data        = '0;

   // Stimulus queue and expected colors
   pixel_beat_type pending_beats[$];
   color_type      expected_colors[$];

   // Predictor state, updated on accepted beats
   logic [23:0] palette_shadow[DEPTH];
   logic [15:0] cur_low     = 16'd0;
   logic [15:0] cur_high    = 16'd65535;
   logic [10:0] cur_entries = 11'd1024;

   // Generator view of the configuration and of which entries hold data
   logic [15:0] plan_low     = 16'd0;
   logic [15:0] plan_high    = 16'd65535;
   logic [10:0] plan_entries = 11'd1024;
   bit          plan_written[DEPTH];

   // Handshake bookkeeping
   logic req_beat = 1'b0;
   logic rsp_beat = 1'b0;
   int   err_count         = 0;
   int   idle_cycles       = 0;
   bit   no_idle           = 1'b0;
   int   long_holds_wanted = 0;
   int   long_holds_done   = 0;
   int   gap_left          = 0;
   int   hold_left         = 0;
   pixel_beat_type next_beat;

   thermal_false_color_mapper i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pixel_value (req_pixel_value),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   // Palette slot picked for a pixel under a given level and entry setting.
   // Clamp the entry count to [2, DEPTH]; a zero or inverted span picks the
   // middle entry, otherwise scale the clamped offset with truncation.
   function automatic logic [9:0] palette_slot(input logic [15:0] pix,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi,
                                               input logic [10:0] ent);
      longint unsigned n;
      longint unsigned s;
      longint unsigned q;
      n = 64'(ent);
      if (n < 64'd2) n = 64'd2;
      if (n > 64'(DEPTH)) n = 64'(DEPTH);
      if (hi <= lo) begin
         q = n / 64'd2;
      end else begin
         s = 64'(pix);
         if (s < 64'(lo)) s = 64'(lo);
         if (s > 64'(hi)) s = 64'(hi);
         q = ((s - 64'(lo)) * (n - 64'd1)) / (64'(hi) - 64'(lo));
      end
      if (q >= 64'(DEPTH)) q = 64'(DEPTH - 1);
      return q[9:0];
   endfunction

   // Mostly short gaps, some medium, a few long; none in a no-idle stretch
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 40) return 0;
      if (roll < 85) return int'($urandom_range(1, 3));
      if (roll < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: launch a beat at the falling edge, hold it until taken,
   // then idle for a random gap before the next one.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_beat) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_beats.size() > 0) begin
            next_beat = pending_beats.pop_front();
            req_valid       <= 1'b1;
            req_op          <= next_beat.op;
            req_pixel_value <= next_beat.pixel;
            req_entry_index <= next_beat.idx;
            req_entry_red   <= next_beat.red;
            req_entry_green <= next_beat.green;
            req_entry_blue  <= next_beat.blue;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: stall for a random stretch after each beat, and
   // hold off for a long stretch on request so the pipeline backs up.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (long_holds_done < long_holds_wanted) begin
            hold_left = LONG_HOLD;
            long_holds_done++;
         end else if (rsp_beat && hold_left == 0) begin
            hold_left = pick_gap();
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample all three channels at the rising edge, track register
   // and palette state, predict each lookup and check each response beat.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      color_type   want;
      logic [23:0] rgb;
      req_beat <= req_valid & req_ready;
      rsp_beat <= rsp_valid & rsp_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_LEVEL:  cur_low     = csr_data;
               CSR_HIGH_LEVEL: cur_high    = csr_data;
               CSR_ENTRIES:    cur_entries = csr_data[10:0];
               default: ;  // unmapped index, drop
            endcase
         end

         // Check the response before queueing a new expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("response beat with no lookup outstanding: rgb %0d/%0d/%0d",
                      rsp_out_red, rsp_out_green, rsp_out_blue);
               err_count++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_out_red !== want.red) begin
                  $error("out_red: expected %0d, actual %0d", want.red, rsp_out_red);
                  err_count++;
               end
               if (rsp_out_green !== want.green) begin
                  $error("out_green: expected %0d, actual %0d", want.green, rsp_out_green);
                  err_count++;
               end
               if (rsp_out_blue !== want.blue) begin
                  $error("out_blue: expected %0d, actual %0d", want.blue, rsp_out_blue);
                  err_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            if (req_op == OP_WRITE) begin
               palette_shadow[req_entry_index] =
                  {req_entry_red, req_entry_green, req_entry_blue};
            end else begin
               rgb = palette_shadow[palette_slot(req_pixel_value, cur_low, cur_high,
                                                 cur_entries)];
               want.red   = rgb[23:16];
               want.green = rgb[15:8];
               want.blue  = rgb[7:0];
               expected_colors = {expected_colors, want};
            end
         end

         // Watchdog: any beat on any channel counts as progress
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_write(input logic [9:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
      pixel_beat_type it;
      it.op    = OP_WRITE;
      it.pixel = 16'($urandom);
      it.idx   = idx;
      it.red   = r;
      it.green = g;
      it.blue  = b;
      plan_written[idx] = 1'b1;
      pending_beats = {pending_beats, it};
   endtask

   // Queue a lookup; fill its slot first if nothing was written there yet
   task automatic push_map(input logic [15:0] pix);
      pixel_beat_type it;
      logic [9:0]     slot;
      slot = palette_slot(pix, plan_low, plan_high, plan_entries);
      if (!plan_written[slot]) begin
         push_write(slot, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      it.op    = OP_MAP;
      it.pixel = pix;
      it.idx   = 10'($urandom);
      it.red   = 8'($urandom);
      it.green = 8'($urandom);
      it.blue  = 8'($urandom);
      pending_beats = {pending_beats, it};
   endtask

   // Pixels biased toward the clamp edges and the active window
   function automatic logic [15:0] pick_pixel();
      int lo;
      int hi;
      lo = (plan_low < plan_high) ? int'(plan_low) : int'(plan_high);
      hi = (plan_low < plan_high) ? int'(plan_high) : int'(plan_low);
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'(lo);
         3:       return 16'(hi);
         4:       return 16'(lo - 1);
         5:       return 16'(hi + 1);
         6, 7:    return 16'($urandom_range(lo, hi));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_traffic(input int count);
      repeat (count) begin
         if ($urandom_range(0, 9) < 3)
            push_write(10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else
            push_map(pick_pixel());
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Program all three registers; random filler in the unused entry bits
   task automatic set_levels(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [10:0] ent);
      logic [15:0] ent_word;
      ent_word        = 16'(ent);
      ent_word[15:11] = 5'($urandom_range(0, 31));
      write_csr(CSR_LOW_LEVEL, lo);
      write_csr(CSR_HIGH_LEVEL, hi);
      write_csr(CSR_ENTRIES, ent_word);
      @(negedge clock);
      csr_valid <= 1'b0;
      plan_low     = lo;
      plan_high    = hi;
      plan_entries = ent;
   endtask

   // Wait until every beat is taken and every color is back, then let
   // trailing palette writes settle before touching the registers.
   task automatic drain();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_colors.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats under reset levels: full range, 1024 entries
      push_write(10'd0, 8'hFF, 8'hFF, 8'hFF);
      push_write(10'd1023, 8'h00, 8'h00, 8'h00);
      push_write(10'd511, 8'hAA, 8'h55, 8'hF0);
      push_map(16'd0);
      push_map(16'hFFFF);
      push_map(16'd32768);
      push_write(10'd511, 8'h55, 8'hAA, 8'h0F);  // overwrite, then read back in order
      push_map(16'd32768);
      push_map(16'd1);
      push_map(16'hFFFE);
      push_map(16'h5555);
      push_map(16'hAAAA);
      drain();

      // Unmapped register index must leave the levels alone
      write_csr(CSR_SPARE, 16'hFFFF);
      @(negedge clock);
      csr_valid <= 1'b0;
      push_map(16'd32768);
      drain();

      // Long receiver hold-off while the sender keeps offering beats
      long_holds_wanted = 1;
      random_traffic(60);
      drain();

      // Directed register settings, extremes included
      set_levels(16'd1000, 16'd3000, 11'd256);   random_traffic(40); drain();
      set_levels(16'd5000, 16'd5000, 11'd100);   random_traffic(30); drain();  // zero span
      set_levels(16'd40000, 16'd20000, 11'd17);  random_traffic(30); drain();  // inverted
      set_levels(16'd0, 16'd65535, 11'd2);       random_traffic(30); drain();  // fewest entries
      no_idle = 1'b1;
      set_levels(16'd100, 16'd101, 11'd1024);    random_traffic(50); drain();  // one-step span
      no_idle = 1'b0;
      set_levels(16'd300, 16'd60000, 11'd0);     random_traffic(30); drain();  // count below 2
      set_levels(16'd0, 16'd65535, 11'd2047);    random_traffic(40); drain();  // count above depth
      set_levels(16'd65535, 16'd65535, 11'd1);   random_traffic(20); drain();
      set_levels(16'd0, 16'd1, 11'd1000);        random_traffic(30); drain();
      set_levels(16'd65534, 16'd65535, 11'd1025); random_traffic(20); drain();

      // Random settings, most counts legal, with one more long hold-off
      long_holds_wanted = 2;
      repeat (5) begin
         set_levels(16'($urandom), 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                : 11'($urandom_range(2, 1024)));
         random_traffic(50);
         drain();
      end

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/tfcm_pkg.sv
rtl/tfcm_div_stage.sv
rtl/thermal_false_color_mapper.sv
dv/tb_top.sv
